### design/lam_pkg.sv
// package for the level alarm monitor
// types, register map, reset values and default sizes; no dependencies
package lam_pkg;

  localparam int WINDOW_DEF       = 8;
  localparam int SAMPLE_WIDTH_DEF = 12;

  localparam int THR_WIDTH   = 12;
  localparam int BEEP_WIDTH  = 16;
  localparam int FAIL_WIDTH  = 8;
  localparam int MS_WIDTH    = 16;
  localparam int STATE_WIDTH = 2;
  localparam int DIV_BITS_PER_CYCLE = 4;

  localparam int APB_ADDR_WIDTH = 4;
  localparam int APB_DATA_WIDTH = 32;

  localparam logic [THR_WIDTH-1:0]  HIGH_THRESHOLD_RST = THR_WIDTH'(2800);
  localparam logic [THR_WIDTH-1:0]  LOW_THRESHOLD_RST  = THR_WIDTH'(1200);
  localparam logic [BEEP_WIDTH-1:0] BEEP_PERIOD_RST    = BEEP_WIDTH'(200);
  localparam logic [FAIL_WIDTH-1:0] FAULT_LIMIT_RST    = FAIL_WIDTH'(5);

  typedef enum logic [1:0] {
    REG_HIGH_THRESHOLD = 2'd0,
    REG_LOW_THRESHOLD  = 2'd1,
    REG_BEEP_PERIOD    = 2'd2,
    REG_FAULT_LIMIT    = 2'd3
  } reg_addr_t;

  typedef enum logic [STATE_WIDTH-1:0] {
    MODE_LOW   = 2'd0,
    MODE_HIGH  = 2'd1,
    MODE_FAULT = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_FIN
  } seq_state_t;

endpackage

### design/lam_if.sv
// valid/ready channels of the level alarm monitor: readings in, reports out
// depends on lam_pkg
interface lam_reading_if #(
  parameter int SAMPLE_WIDTH = lam_pkg::SAMPLE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          read_ok;
  logic [SAMPLE_WIDTH-1:0]       raw_sample;
  logic [lam_pkg::MS_WIDTH-1:0]  elapsed_ms;

  modport source (output valid, read_ok, raw_sample, elapsed_ms, input ready);
  modport sink (input valid, read_ok, raw_sample, elapsed_ms, output ready);
endinterface

interface lam_report_if #(
  parameter int SAMPLE_WIDTH = lam_pkg::SAMPLE_WIDTH_DEF
);
  logic                            valid;
  logic                            ready;
  logic [lam_pkg::STATE_WIDTH-1:0] level_state;
  logic                            alarm_on;
  logic [SAMPLE_WIDTH-1:0]         filtered_level;
  logic                            level_valid;
  logic [lam_pkg::FAIL_WIDTH-1:0]  fail_count;

  modport source (output valid, level_state, alarm_on, filtered_level, level_valid,
                  fail_count, input ready);
  modport sink (input valid, level_state, alarm_on, filtered_level, level_valid,
                fail_count, output ready);
endinterface

### design/lam_div.sv
// multicycle restoring divider, a few quotient bits per cycle
// quotient must fit in QW bits; depends on lam_pkg
module lam_div #(
  parameter int QW  = 12,
  parameter int DVW = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [QW+DVW-1:0]   dividend,
  input  logic [DVW-1:0]      divisor,
  output logic                done,
  output logic [QW-1:0]       quotient
);
  import lam_pkg::*;

  localparam int NSTEP = QW / DIV_BITS_PER_CYCLE;
  localparam int CNTW  = $clog2(NSTEP + 1);

  logic [DVW-1:0]  rem;
  logic [QW-1:0]   lo;
  logic [DVW-1:0]  dvs;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [DVW-1:0]  rem_next;
  logic [QW-1:0]   lo_next;

  always_comb begin
    logic [DVW:0] t;
    rem_next = rem;
    lo_next  = lo;
    for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
      t = {rem_next, lo_next[QW-1]};
      lo_next = {lo_next[QW-2:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        t = t - {1'b0, dvs};
        lo_next[0] = 1'b1;
      end
      rem_next = t[DVW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(NSTEP);
        rem  <= dividend[QW+DVW-1:QW];
        lo   <= dividend[QW-1:0];
        dvs  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        lo  <= lo_next;
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = lo;

endmodule

### design/level_alarm_monitor.sv
// level alarm monitor top level: moving average over a sample memory,
// hysteresis comparator, beeping alarm and fault detection
// depends on lam_pkg, lam_if and lam_div
//
// readings arrive on a valid/ready channel; each transfer carries read_ok,
// raw_sample and elapsed_ms. one report leaves on the report channel per
// reading, in order. the four thresholds and limits are to be written over apb
// only while the block is idle; the user must keep to this, as the block does
// not enforce it. pready is tied high. for a good reading the sequencer goes
// from idle to read, where it updates the window and starts the divider that
// forms sum / count at four quotient bits a cycle, then waits in div until the
// divider is done and loads the report in fin. the next reading is taken in the
// cycle after the report is loaded. a failed reading goes from idle straight to
// fin. a new reading is taken once the previous one has been written into the
// report register, so a stalled receiver holds one report while the next
// reading is already in work; a second report waits until the first is taken.
// reset empties the window, returns to low with the alarm off, clears the
// fail count and reloads the register defaults; sample memory is not cleared.
module level_alarm_monitor #(
  parameter int WINDOW       = lam_pkg::WINDOW_DEF,
  parameter int SAMPLE_WIDTH = lam_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  lam_reading_if.sink                        reading,
  lam_report_if.source                       report,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lam_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [lam_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [lam_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                               pready
);
  import lam_pkg::*;

  localparam int CW     = $clog2(WINDOW + 1);
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int SUMW   = SAMPLE_WIDTH + CW;
  localparam int QW     = ((SAMPLE_WIDTH + DIV_BITS_PER_CYCLE - 1) / DIV_BITS_PER_CYCLE)
                          * DIV_BITS_PER_CYCLE;
  localparam int CMPW   = (SAMPLE_WIDTH > THR_WIDTH) ? SAMPLE_WIDTH : THR_WIDTH;

  logic [THR_WIDTH-1:0]  high_threshold;
  logic [THR_WIDTH-1:0]  low_threshold;
  logic [BEEP_WIDTH-1:0] beep_period;
  logic [FAIL_WIDTH-1:0] fault_limit;

  seq_state_t state, state_next;

  logic                    it_ok;
  logic [SAMPLE_WIDTH-1:0] it_raw;
  logic [MS_WIDTH-1:0]     it_elapsed;

  logic [SLOT_W-1:0]     write_slot;
  logic [CW-1:0]         held_count;
  logic [SUMW-1:0]       running_sum;
  mode_t                 mode;
  logic                  alarm_bit;
  logic [MS_WIDTH-1:0]   since_toggle_ms;
  logic [FAIL_WIDTH-1:0] fail_counter;

  logic [SAMPLE_WIDTH-1:0] window_mem [WINDOW];
  logic [SAMPLE_WIDTH-1:0] rd_data;
  logic [SLOT_W-1:0]       rd_addr;
  logic                    mem_re;
  logic                    mem_we;

  logic                      out_valid;
  mode_t                     out_mode;
  logic                      out_alarm;
  logic [SAMPLE_WIDTH-1:0]   out_filtered;
  logic                      out_level_valid;
  logic [FAIL_WIDTH-1:0]     out_fail;

  logic                    accept;
  logic                    cfg_write;
  logic                    held_full;
  logic [SLOT_W-1:0]       slot_next;
  logic [CW-1:0]           held_next;
  logic [SUMW-1:0]         sum_next;
  logic                    div_start;
  logic                    div_done;
  logic [QW-1:0]           quotient;
  logic                    can_load;

  logic [SAMPLE_WIDTH-1:0] filtered;
  mode_t                   mode_next;
  logic                    alarm_next;
  logic [MS_WIDTH-1:0]     since_next;
  logic [FAIL_WIDTH-1:0]   fail_next;
  logic [MS_WIDTH:0]       since_sum;
  logic [MS_WIDTH-1:0]     since_sat;

  // apb register file
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_comb begin
    unique case (reg_addr_t'(paddr[3:2]))
      REG_HIGH_THRESHOLD: prdata = APB_DATA_WIDTH'(high_threshold);
      REG_LOW_THRESHOLD:  prdata = APB_DATA_WIDTH'(low_threshold);
      REG_BEEP_PERIOD:    prdata = APB_DATA_WIDTH'(beep_period);
      REG_FAULT_LIMIT:    prdata = APB_DATA_WIDTH'(fault_limit);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_threshold <= HIGH_THRESHOLD_RST;
      low_threshold  <= LOW_THRESHOLD_RST;
      beep_period    <= BEEP_PERIOD_RST;
      fault_limit    <= FAULT_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (reg_addr_t'(paddr[3:2]))
        REG_HIGH_THRESHOLD: high_threshold <= pwdata[THR_WIDTH-1:0];
        REG_LOW_THRESHOLD:  low_threshold  <= pwdata[THR_WIDTH-1:0];
        REG_BEEP_PERIOD:    beep_period    <= pwdata[BEEP_WIDTH-1:0];
        REG_FAULT_LIMIT:    fault_limit    <= pwdata[FAIL_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // sample memory
  assign rd_addr = (reading.read_ok && mode == MODE_FAULT) ? '0 : write_slot;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      window_mem[write_slot] <= it_raw;
    end
    if (mem_re) begin
      rd_data <= window_mem[rd_addr];
    end
  end

  // window update
  assign held_full = (held_count == CW'(WINDOW));
  assign slot_next = (write_slot == SLOT_W'(WINDOW - 1)) ? '0 : write_slot + 1'b1;
  assign held_next = held_full ? held_count : held_count + 1'b1;
  assign sum_next  = running_sum - (held_full ? SUMW'(rd_data) : '0) + SUMW'(it_raw);

  lam_div #(
    .QW  (QW),
    .DVW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ((QW + CW)'(sum_next)),
    .divisor  (held_next),
    .done     (div_done),
    .quotient (quotient)
  );

  // mode, alarm and fail count for the finishing item
  assign since_sum = {1'b0, since_toggle_ms} + {1'b0, it_elapsed};
  assign since_sat = since_sum[MS_WIDTH] ? '1 : since_sum[MS_WIDTH-1:0];

  always_comb begin
    filtered   = '0;
    mode_next  = mode;
    alarm_next = alarm_bit;
    since_next = since_sat;
    fail_next  = fail_counter;
    if (it_ok) begin
      filtered  = quotient[SAMPLE_WIDTH-1:0];
      fail_next = '0;
      unique case (mode)
        MODE_HIGH: begin
          mode_next = (CMPW'(filtered) < CMPW'(low_threshold)) ? MODE_LOW : MODE_HIGH;
        end
        default: begin
          mode_next = (CMPW'(filtered) > CMPW'(high_threshold)) ? MODE_HIGH : MODE_LOW;
        end
      endcase
      if (mode_next == MODE_HIGH) begin
        if (since_sat >= beep_period) begin
          alarm_next = ~alarm_bit;
          since_next = '0;
        end
      end else begin
        alarm_next = 1'b0;
      end
    end else begin
      if (fail_counter != '1) begin
        fail_next = fail_counter + 1'b1;
      end
      if (fail_next >= fault_limit && mode != MODE_FAULT) begin
        mode_next  = MODE_FAULT;
        alarm_next = 1'b0;
      end
    end
  end

  // sequencer
  assign accept   = reading.valid & reading.ready;
  assign can_load = ~out_valid | report.ready;

  always_comb begin
    state_next    = state;
    reading.ready = 1'b0;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    div_start     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        reading.ready = 1'b1;
        mem_re        = reading.valid;
        if (reading.valid) begin
          state_next = reading.read_ok ? ST_READ : ST_FIN;
        end
      end
      ST_READ: begin
        mem_we     = 1'b1;
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (can_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_ok      <= reading.read_ok;
      it_raw     <= reading.raw_sample;
      it_elapsed <= reading.elapsed_ms;
    end
    if (state == ST_FIN && can_load) begin
      out_mode        <= mode_next;
      out_alarm       <= alarm_next;
      out_filtered    <= filtered;
      out_level_valid <= it_ok;
      out_fail        <= fail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      write_slot      <= '0;
      held_count      <= '0;
      running_sum     <= '0;
      mode            <= MODE_LOW;
      alarm_bit       <= 1'b0;
      since_toggle_ms <= '0;
      fail_counter    <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (report.ready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && reading.read_ok && mode == MODE_FAULT) begin
            write_slot  <= '0;
            held_count  <= '0;
            running_sum <= '0;
            mode        <= MODE_LOW;
          end
        end
        ST_READ: begin
          write_slot  <= slot_next;
          held_count  <= held_next;
          running_sum <= sum_next;
        end
        ST_FIN: begin
          if (can_load) begin
            mode            <= mode_next;
            alarm_bit       <= alarm_next;
            since_toggle_ms <= since_next;
            fail_counter    <= fail_next;
            out_valid       <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign report.valid          = out_valid;
  assign report.level_state    = out_mode;
  assign report.alarm_on       = out_alarm;
  assign report.filtered_level = out_filtered;
  assign report.level_valid    = out_level_valid;
  assign report.fail_count     = out_fail;

endmodule
